[hw/rtl/crb_pkg.sv]
// shared types, constants and helpers for the clipped raster-operation blitter
// used by crb_regs, crb_ctrl, crb_dp and clipped_rop_blitter; no dependencies
package crb_pkg;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned PIX_W   = 32;
  localparam int unsigned ADDR_W  = 2 * COORD_W;
  localparam int unsigned DEPTH   = 1 << ADDR_W;
  localparam int unsigned MAX_DIM = 1 << COORD_W;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned ROP_W   = 3;
  localparam int unsigned IN_W    = 88;
  localparam int unsigned OUT_W   = 56;
  localparam int unsigned CFG_AW  = 4;
  localparam int unsigned CFG_DW  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_WR_SRC = 3'd0,
    OP_WR_DST = 3'd1,
    OP_RD_SRC = 3'd2,
    OP_RD_DST = 3'd3,
    OP_BLIT   = 3'd4
  } op_e;

  typedef enum logic [ROP_W-1:0] {
    ROP_SRCCOPY   = 3'd0,
    ROP_SRCAND    = 3'd1,
    ROP_SRCPAINT  = 3'd2,
    ROP_SRCINVERT = 3'd3
  } rop_e;

  typedef enum logic [1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_BLIT,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] dst_w;
    logic [DIM_W-1:0] dst_h;
  } dims_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic blit_step;
    logic capture;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_run;
    logic blit_last;
  } stat_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

  function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
                                               input logic [DIM_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

[hw/rtl/crb_regs.sv]
// surface size registers behind the apb-style configuration port
// depends on crb_pkg; hands saturated sizes to the datapath
module crb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crb_pkg::CFG_AW-1:0]  paddr,
  input  logic [crb_pkg::CFG_DW-1:0]  pwdata,
  output logic [crb_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output crb_pkg::dims_t              dims_o
);

  logic [crb_pkg::DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic                      wr_en;
  crb_pkg::reg_e             sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = crb_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= crb_pkg::DIM_W'(crb_pkg::MAX_DIM);
      src_h_q <= crb_pkg::DIM_W'(crb_pkg::MAX_DIM);
      dst_w_q <= crb_pkg::DIM_W'(crb_pkg::MAX_DIM);
      dst_h_q <= crb_pkg::DIM_W'(crb_pkg::MAX_DIM);
    end else if (wr_en) begin
      unique case (sel)
        crb_pkg::REG_SRC_W: src_w_q <= pwdata[crb_pkg::DIM_W-1:0];
        crb_pkg::REG_SRC_H: src_h_q <= pwdata[crb_pkg::DIM_W-1:0];
        crb_pkg::REG_DST_W: dst_w_q <= pwdata[crb_pkg::DIM_W-1:0];
        crb_pkg::REG_DST_H: dst_h_q <= pwdata[crb_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      crb_pkg::REG_SRC_W: prdata = crb_pkg::CFG_DW'(src_w_q);
      crb_pkg::REG_SRC_H: prdata = crb_pkg::CFG_DW'(src_h_q);
      crb_pkg::REG_DST_W: prdata = crb_pkg::CFG_DW'(dst_w_q);
      crb_pkg::REG_DST_H: prdata = crb_pkg::CFG_DW'(dst_h_q);
      default:            prdata = '0;
    endcase
  end

  assign dims_o.src_w = crb_pkg::sat_dim(src_w_q);
  assign dims_o.src_h = crb_pkg::sat_dim(src_h_q);
  assign dims_o.dst_w = crb_pkg::sat_dim(dst_w_q);
  assign dims_o.dst_h = crb_pkg::sat_dim(dst_h_q);

endmodule

[hw/rtl/crb_ctrl.sv]
// controller state machine: sequences access, blit sweep and result handoff
// depends on crb_pkg; drives crb_dp through cmd_t, reads stat_t back
module crb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  crb_pkg::stat_t stat_i,
  output crb_pkg::cmd_t  cmd_o
);

  crb_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            load_out;

  assign load_out = (state_q == crb_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crb_pkg::ST_IDLE:   if (in_valid_i) state_d = crb_pkg::ST_EXEC;
      crb_pkg::ST_EXEC: begin
        if (stat_i.is_read) begin
          state_d = crb_pkg::ST_RDWAIT;
        end else if (stat_i.is_run) begin
          state_d = crb_pkg::ST_BLIT;
        end else begin
          state_d = crb_pkg::ST_DONE;
        end
      end
      crb_pkg::ST_RDWAIT: state_d = crb_pkg::ST_DONE;
      crb_pkg::ST_BLIT:   if (stat_i.blit_last) state_d = crb_pkg::ST_DRAIN;
      crb_pkg::ST_DRAIN:  state_d = crb_pkg::ST_DONE;
      crb_pkg::ST_DONE:   if (load_out) state_d = crb_pkg::ST_IDLE;
      default:            state_d = crb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == crb_pkg::ST_IDLE);
    cmd_o.load_in     = (state_q == crb_pkg::ST_IDLE) && in_valid_i;
    cmd_o.exec        = (state_q == crb_pkg::ST_EXEC);
    cmd_o.blit_step   = (state_q == crb_pkg::ST_BLIT);
    cmd_o.capture     = (state_q == crb_pkg::ST_RDWAIT);
    cmd_o.load_out    = load_out;
    out_valid_d       = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/crb_dp.sv]
// datapath: input beat registers, bounds and clipping, both surface memories,
// raster-op write stage and result registers; depends on crb_pkg
module crb_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  crb_pkg::cmd_t              cmd_i,
  output crb_pkg::stat_t             stat_o,
  input  crb_pkg::dims_t             dims_i,
  input  logic [crb_pkg::IN_W-1:0]   in_data_i,
  input  logic [crb_pkg::OP_W-1:0]   in_user_i,
  output logic [crb_pkg::OUT_W-1:0]  out_data_o
);

  localparam int unsigned CW = crb_pkg::COORD_W;
  localparam int unsigned DW = crb_pkg::DIM_W;
  localparam int unsigned PW = crb_pkg::PIX_W;
  localparam int unsigned AW = crb_pkg::ADDR_W;

  // input beat
  logic [crb_pkg::OP_W-1:0]  op_q;
  logic [CW-1:0]             px_q, py_q, fx_q, fy_q;
  logic [DW-1:0]             rw_q, rh_q;
  logic [crb_pkg::ROP_W-1:0] rop_q;
  logic [PW-1:0]             pin_q;

  // surfaces
  logic [PW-1:0] src_mem [crb_pkg::DEPTH];
  logic [PW-1:0] dst_mem [crb_pkg::DEPTH];
  logic [PW-1:0] src_rdata_q, dst_rdata_q;

  // sweep and write stage
  logic [CW-1:0] x_q, y_q;
  logic          wr_v_q;
  logic [AW-1:0] wr_addr_q;

  // result
  logic [PW-1:0] res_pix_q;
  logic          res_status_q;
  logic [DW-1:0] res_cw_q, res_ch_q;
  logic [PW-1:0] out_pix_q;
  logic          out_status_q;
  logic [DW-1:0] out_cw_q, out_ch_q;

  crb_pkg::op_e  op;
  logic          on_src, acc_ok, blit_ok, rop_known, x_last;
  logic [DW-1:0] lim_w, lim_h, clip_w, clip_h;
  logic [AW-1:0] acc_addr, bsrc_addr, bdst_addr, src_raddr, dst_waddr, dst_raddr;
  logic          src_we, src_re, dst_we, dst_re;
  logic [PW-1:0] rop_res, dst_wdata;

  assign op        = crb_pkg::op_e'(op_q);
  assign on_src    = (op == crb_pkg::OP_WR_SRC) || (op == crb_pkg::OP_RD_SRC);
  assign lim_w     = on_src ? dims_i.src_w : dims_i.dst_w;
  assign lim_h     = on_src ? dims_i.src_h : dims_i.dst_h;
  assign acc_ok    = (DW'(px_q) < lim_w) && (DW'(py_q) < lim_h);
  assign blit_ok   = (DW'(fx_q) < dims_i.src_w) && (DW'(fy_q) < dims_i.src_h) &&
                     (DW'(px_q) < dims_i.dst_w) && (DW'(py_q) < dims_i.dst_h);
  assign rop_known = (rop_q <= crb_pkg::ROP_W'(crb_pkg::ROP_SRCINVERT));

  assign clip_w = crb_pkg::min_dim(crb_pkg::min_dim(rw_q, dims_i.src_w - DW'(fx_q)),
                                   dims_i.dst_w - DW'(px_q));
  assign clip_h = crb_pkg::min_dim(crb_pkg::min_dim(rh_q, dims_i.src_h - DW'(fy_q)),
                                   dims_i.dst_h - DW'(py_q));

  assign stat_o.is_read   = ((op == crb_pkg::OP_RD_SRC) || (op == crb_pkg::OP_RD_DST)) && acc_ok;
  assign stat_o.is_run    = (op == crb_pkg::OP_BLIT) && blit_ok && rop_known &&
                            (clip_w != '0) && (clip_h != '0);
  assign x_last           = ((DW'(x_q) + DW'(1)) == res_cw_q);
  assign stat_o.blit_last = x_last && ((DW'(y_q) + DW'(1)) == res_ch_q);

  assign acc_addr  = {py_q, px_q};
  assign bsrc_addr = {fy_q + y_q, fx_q + x_q};
  assign bdst_addr = {py_q + y_q, px_q + x_q};

  always_comb begin
    unique case (crb_pkg::rop_e'(rop_q))
      crb_pkg::ROP_SRCCOPY:   rop_res = src_rdata_q;
      crb_pkg::ROP_SRCAND:    rop_res = dst_rdata_q & src_rdata_q;
      crb_pkg::ROP_SRCPAINT:  rop_res = dst_rdata_q | src_rdata_q;
      crb_pkg::ROP_SRCINVERT: rop_res = dst_rdata_q ^ src_rdata_q;
      default:                rop_res = dst_rdata_q;
    endcase
  end

  assign src_we    = cmd_i.exec && (op == crb_pkg::OP_WR_SRC) && acc_ok;
  assign src_re    = cmd_i.blit_step || (cmd_i.exec && (op == crb_pkg::OP_RD_SRC) && acc_ok);
  assign src_raddr = cmd_i.blit_step ? bsrc_addr : acc_addr;
  assign dst_we    = wr_v_q || (cmd_i.exec && (op == crb_pkg::OP_WR_DST) && acc_ok);
  assign dst_waddr = wr_v_q ? wr_addr_q : acc_addr;
  assign dst_wdata = wr_v_q ? rop_res : pin_q;
  assign dst_re    = cmd_i.blit_step || (cmd_i.exec && (op == crb_pkg::OP_RD_DST) && acc_ok);
  assign dst_raddr = cmd_i.blit_step ? bdst_addr : acc_addr;

  always_ff @(posedge clk_i) begin
    if (src_we) src_mem[acc_addr] <= pin_q;
    if (src_re) src_rdata_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dst_we) dst_mem[dst_waddr] <= dst_wdata;
    if (dst_re) dst_rdata_q <= dst_mem[dst_raddr];
  end

  // input beat fields, lowest first
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= in_user_i;
      px_q  <= in_data_i[7:0];
      py_q  <= in_data_i[15:8];
      fx_q  <= in_data_i[23:16];
      fy_q  <= in_data_i[31:24];
      rw_q  <= in_data_i[40:32];
      rh_q  <= in_data_i[49:41];
      rop_q <= in_data_i[52:50];
      pin_q <= in_data_i[84:53];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      wr_v_q <= 1'b0;
    end else begin
      wr_v_q <= cmd_i.blit_step;
      if (cmd_i.exec) begin
        x_q <= '0;
        y_q <= '0;
      end else if (cmd_i.blit_step) begin
        if (x_last) begin
          x_q <= '0;
          y_q <= y_q + CW'(1);
        end else begin
          x_q <= x_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.blit_step) wr_addr_q <= bdst_addr;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_pix_q <= '0;
      res_cw_q  <= '0;
      res_ch_q  <= '0;
      unique case (op)
        crb_pkg::OP_WR_SRC, crb_pkg::OP_WR_DST,
        crb_pkg::OP_RD_SRC, crb_pkg::OP_RD_DST: res_status_q <= !acc_ok;
        crb_pkg::OP_BLIT: begin
          res_status_q <= !blit_ok;
          if (blit_ok) begin
            res_cw_q <= clip_w;
            res_ch_q <= clip_h;
          end
        end
        default: res_status_q <= 1'b0;
      endcase
    end else if (cmd_i.capture) begin
      res_pix_q <= on_src ? src_rdata_q : dst_rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_pix_q    <= res_pix_q;
      out_status_q <= res_status_q;
      out_cw_q     <= res_cw_q;
      out_ch_q     <= res_ch_q;
    end
  end

  assign out_data_o = {5'b0, out_ch_q, out_cw_q, out_status_q, out_pix_q};

endmodule

[hw/rtl/clipped_rop_blitter.sv]
// clipped raster-operation blitter, top level
// depends on crb_pkg, crb_regs, crb_ctrl and crb_dp
//
// usage:
//   slave stream carries one command per beat: tuser is the operation
//   (write source, write dest, read source, read dest, blit); tdata holds
//   coordinates, rectangle size, raster code and write pixel.
//   master stream returns one result beat per command: read pixel, status
//   (1 = coordinate outside its surface) and clipped blit width and height.
//   the apb-style port holds the four surface size registers (reset 256,
//   values above 256 act as 256); write them only while the block is idle.
//   one command is worked on at a time; tready is high only in the idle state.
//   a blit moves one pixel per cycle through a registered read of both
//   surfaces followed by the raster-op write to the destination.
//   the result waits in an output register; the block stays in its final
//   state while an earlier beat is still untaken, then tready returns.
//   reset returns the controller to idle with no result pending; surface
//   contents are undefined until written and are not cleared.
module clipped_rop_blitter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // pos_x, pos_y, from_x, from_y, rect_width, rect_height, rop, pixel_in, pad
  input  logic [crb_pkg::IN_W-1:0]    s_axis_tdata,
  // operation
  input  logic [crb_pkg::OP_W-1:0]    s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // pixel_out, status, copied_width, copied_height, pad
  output logic [crb_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [crb_pkg::CFG_AW-1:0]  paddr,
  input  logic [crb_pkg::CFG_DW-1:0]  pwdata,
  output logic [crb_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  crb_pkg::dims_t dims;
  crb_pkg::cmd_t  cmd;
  crb_pkg::stat_t stat;

  crb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims_o  (dims)
  );

  crb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  crb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .dims_i     (dims),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .out_data_o (m_axis_tdata)
  );

endmodule

[sim/tb_top.sv]
// testbench for clipped_rop_blitter: directed stimulus table, then random commands under
// several surface size settings, checked beat by beat against a behavioral pixel-surface model
// depends on crb_pkg and the clipped_rop_blitter rtl
module tb_top;
  import crb_pkg::*;

  localparam logic [OP_W-1:0]  OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0]  OP_SPARE_HI = 3'd7;
  localparam logic [ROP_W-1:0] ROP_NOP     = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] from_x;
    logic [COORD_W-1:0] from_y;
    logic [DIM_W-1:0]   rect_w;
    logic [DIM_W-1:0]   rect_h;
    logic [ROP_W-1:0]   rop;
    logic [PIX_W-1:0]   pixel;
  } blit_cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             status;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } blit_res_t;

  typedef struct {
    bit        is_cfg;
    reg_e      cfg_reg;
    int        cfg_val;
    blit_cmd_t c;
    bit        typed;
    blit_res_t want;
  } step_row_t;

  typedef int coord_q_t[$];

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic [OP_W-1:0]   s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  clipped_rop_blitter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int               dim_reg[4] = '{256, 256, 256, 256};
  logic [PIX_W-1:0] src_pix[DEPTH];
  logic [PIX_W-1:0] dst_pix[DEPTH];
  bit               src_known[DEPTH];
  bit               dst_known[DEPTH];
  blit_res_t        pending_results[$];
  int               mismatch_count = 0;
  int               send_gap_pct = 12;
  int               recv_stall_pct = 84;

  function automatic int active_dim(reg_e r);
    return (dim_reg[r] > int'(MAX_DIM)) ? int'(MAX_DIM) : dim_reg[r];
  endfunction

  function automatic int cell_of(int x, int y);
    return (y * int'(MAX_DIM) + x) % int'(DEPTH);
  endfunction

  function automatic bit access_cell(blit_cmd_t c, output int a);
    bit on_src = (c.op == OP_WR_SRC || c.op == OP_RD_SRC);
    int w = on_src ? active_dim(REG_SRC_W) : active_dim(REG_DST_W);
    int h = on_src ? active_dim(REG_SRC_H) : active_dim(REG_DST_H);
    a = cell_of(c.pos_x, c.pos_y);
    return int'(c.pos_x) < w && int'(c.pos_y) < h;
  endfunction

  function automatic bit blit_window(blit_cmd_t c, output int cw, output int ch);
    int sw = active_dim(REG_SRC_W);
    int sh = active_dim(REG_SRC_H);
    int dw = active_dim(REG_DST_W);
    int dh = active_dim(REG_DST_H);
    cw = 0;
    ch = 0;
    if (int'(c.from_x) >= sw || int'(c.from_y) >= sh || int'(c.pos_x) >= dw ||
        int'(c.pos_y) >= dh) begin
      return 1'b0;
    end
    cw = c.rect_w;
    if (sw - int'(c.from_x) < cw) cw = sw - int'(c.from_x);
    if (dw - int'(c.pos_x) < cw) cw = dw - int'(c.pos_x);
    ch = c.rect_h;
    if (sh - int'(c.from_y) < ch) ch = sh - int'(c.from_y);
    if (dh - int'(c.pos_y) < ch) ch = dh - int'(c.pos_y);
    return 1'b1;
  endfunction

  // updates the surface copies and returns the result beat the command causes
  function automatic blit_res_t compute_result(blit_cmd_t c);
    blit_res_t        r;
    int               a, cw, ch, x, y, si, di;
    logic [PIX_W-1:0] s, d;
    r = '0;
    if (c.op <= OP_RD_DST) begin
      if (!access_cell(c, a)) begin
        r.status = 1'b1;
      end else begin
        case (c.op)
          OP_WR_SRC: begin
            src_pix[a] = c.pixel;
            src_known[a] = 1'b1;
          end
          OP_WR_DST: begin
            dst_pix[a] = c.pixel;
            dst_known[a] = 1'b1;
          end
          OP_RD_SRC: r.pixel = src_pix[a];
          default:   r.pixel = dst_pix[a];
        endcase
      end
    end else if (c.op == OP_BLIT) begin
      if (!blit_window(c, cw, ch)) begin
        r.status = 1'b1;
      end else begin
        r.width = cw;
        r.height = ch;
        if (c.rop <= ROP_SRCINVERT) begin
          for (y = 0; y < ch; y++) begin
            for (x = 0; x < cw; x++) begin
              si = cell_of(c.from_x + x, c.from_y + y);
              di = cell_of(c.pos_x + x, c.pos_y + y);
              s = src_pix[si];
              d = dst_pix[di];
              case (c.rop)
                ROP_SRCCOPY:  dst_pix[di] = s;
                ROP_SRCAND:   dst_pix[di] = d & s;
                ROP_SRCPAINT: dst_pix[di] = d | s;
                default:      dst_pix[di] = d ^ s;
              endcase
              dst_known[di] = 1'b1;
            end
          end
        end
      end
    end
    return r;
  endfunction

  // true when the command would read a surface entry that was never written
  function automatic bit reads_unwritten(blit_cmd_t c);
    int a, cw, ch, x, y;
    if (c.op == OP_RD_SRC) return access_cell(c, a) && !src_known[a];
    if (c.op == OP_RD_DST) return access_cell(c, a) && !dst_known[a];
    if (c.op == OP_BLIT && blit_window(c, cw, ch)) begin
      for (y = 0; y < ch; y++) begin
        for (x = 0; x < cw; x++) begin
          if (!src_known[cell_of(c.from_x + x, c.from_y + y)] ||
              !dst_known[cell_of(c.pos_x + x, c.pos_y + y)]) begin
            return 1'b1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // corners of large surfaces, whole small surfaces
  function automatic coord_q_t band_coords(int n);
    coord_q_t q;
    int i;
    for (i = 0; i < n; i++) begin
      if (n <= 8 || i < 4 || i >= n - 4) q.push_back(i);
    end
    return q;
  endfunction

  function automatic int pick_pos(int n);
    int r = $urandom_range(0, 99);
    if (n == 0 || r < 15) return $urandom_range(0, 255);
    if (n <= 8) return $urandom_range(0, n - 1);
    if (r < 57) return $urandom_range(0, 3);
    return $urandom_range(n - 4, n - 1);
  endfunction

  function automatic int pick_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 4);
    if (r < 85) return $urandom_range(0, 16);
    if (r < 93) return MAX_DIM;
    return $urandom_range(0, MAX_DIM);
  endfunction

  function automatic int rand_dim();
    int r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return $urandom_range(MAX_DIM + 1, 511);
    if (r < 30) return $urandom_range(200, MAX_DIM);
    return $urandom_range(1, 10);
  endfunction

  function automatic blit_cmd_t random_cmd();
    blit_cmd_t c;
    int r, tries;
    bit on_src;
    for (tries = 0; tries < 20; tries++) begin
      r = $urandom_range(0, 99);
      if (r < 20) c.op = $urandom_range(0, 1) ? OP_WR_DST : OP_WR_SRC;
      else if (r < 40) c.op = $urandom_range(0, 1) ? OP_RD_DST : OP_RD_SRC;
      else if (r < 90) c.op = OP_BLIT;
      else c.op = $urandom_range(OP_SPARE_LO, OP_SPARE_HI);
      on_src = (c.op == OP_WR_SRC || c.op == OP_RD_SRC);
      c.pos_x = pick_pos(on_src ? active_dim(REG_SRC_W) : active_dim(REG_DST_W));
      c.pos_y = pick_pos(on_src ? active_dim(REG_SRC_H) : active_dim(REG_DST_H));
      c.from_x = pick_pos(active_dim(REG_SRC_W));
      c.from_y = pick_pos(active_dim(REG_SRC_H));
      c.rect_w = pick_len();
      c.rect_h = pick_len();
      c.rop = $urandom_range(0, 7);
      c.pixel = $urandom;
      if (!reads_unwritten(c)) return c;
    end
    c.op = OP_BLIT;
    c.rect_h = '0;
    return c;
  endfunction

  function automatic blit_cmd_t mk(logic [OP_W-1:0] op, int px, int py, int fx, int fy,
                                   int rw, int rh, logic [ROP_W-1:0] rop,
                                   logic [PIX_W-1:0] pix);
    blit_cmd_t c;
    c.op = op;
    c.pos_x = px;
    c.pos_y = py;
    c.from_x = fx;
    c.from_y = fy;
    c.rect_w = rw;
    c.rect_h = rh;
    c.rop = rop;
    c.pixel = pix;
    return c;
  endfunction

  function automatic step_row_t row_item(blit_cmd_t c);
    step_row_t s;
    s.is_cfg = 1'b0;
    s.c = c;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_row_t row_chk(blit_cmd_t c, logic [PIX_W-1:0] pix, bit st,
                                        int w, int h);
    step_row_t s = row_item(c);
    s.typed = 1'b1;
    s.want.pixel = pix;
    s.want.status = st;
    s.want.width = w;
    s.want.height = h;
    return s;
  endfunction

  function automatic step_row_t row_cfg(reg_e r, int v);
    step_row_t s = row_item('0);
    s.is_cfg = 1'b1;
    s.cfg_reg = r;
    s.cfg_val = v;
    return s;
  endfunction

  task automatic issue_beat(blit_cmd_t c, blit_res_t want);
    pending_results.push_back(want);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.op;
    s_axis_tdata <= {3'b000, c.pixel, c.rop, c.rect_h, c.rect_w,
                     c.from_y, c.from_x, c.pos_y, c.pos_x};
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_gap_pct);
    end
  endtask

  // stop sending and wait until every expected beat has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, int v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= (v & 32'h1ff) | ($urandom & ~32'h1ff);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dim_reg[r] = v & 32'h1ff;
  endtask

  task automatic fill_surface(bit on_src);
    coord_q_t  xs, ys;
    blit_cmd_t c;
    xs = band_coords(on_src ? active_dim(REG_SRC_W) : active_dim(REG_DST_W));
    ys = band_coords(on_src ? active_dim(REG_SRC_H) : active_dim(REG_DST_H));
    foreach (ys[j]) begin
      foreach (xs[i]) begin
        c = random_cmd();
        c.op = on_src ? OP_WR_SRC : OP_WR_DST;
        c.pos_x = xs[i];
        c.pos_y = ys[j];
        issue_beat(c, compute_result(c));
      end
    end
  endtask

  task automatic run_setting(int sw, int sh, int dw, int dh, int n);
    blit_cmd_t c;
    int i;
    settle();
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_DST_W, dw);
    write_reg(REG_DST_H, dh);
    fill_surface(1'b1);
    fill_surface(1'b0);
    for (i = 0; i < n; i++) begin
      if (i == n / 2) settle();
      c = random_cmd();
      issue_beat(c, compute_result(c));
    end
  endtask

  always @(posedge clk_i) begin : result_check
    blit_res_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.pixel = m_axis_tdata[31:0];
      got.status = m_axis_tdata[32];
      got.width = m_axis_tdata[41:33];
      got.height = m_axis_tdata[50:42];
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.pixel !== want.pixel) begin
          $error("pixel_out: expected %h, got %h", want.pixel, got.pixel);
          mismatch_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatch_count++;
        end
        if (got.width !== want.width) begin
          $error("copied_width: expected %0d, got %0d", want.width, got.width);
          mismatch_count++;
        end
        if (got.height !== want.height) begin
          $error("copied_height: expected %0d, got %0d", want.height, got.height);
          mismatch_count++;
        end
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    step_row_t steps[$];
    blit_res_t want;
    int k;
    steps.push_back(row_chk(mk(OP_WR_SRC, 0, 0, 255, 255, 256, 256, ROP_NOP, 'hffff_ffff),
                            '0, 0, 0, 0));
    steps.push_back(row_chk(mk(OP_WR_SRC, 255, 255, 0, 0, 0, 0, ROP_SRCCOPY, 'ha5a5_5a5a),
                            '0, 0, 0, 0));
    steps.push_back(row_chk(mk(OP_WR_DST, 0, 0, 0, 0, 0, 0, ROP_SRCCOPY, 'h0f0f_f0f0),
                            '0, 0, 0, 0));
    steps.push_back(row_chk(mk(OP_WR_DST, 255, 255, 0, 0, 0, 0, ROP_SRCCOPY, 'h1234_5678),
                            '0, 0, 0, 0));
    steps.push_back(row_chk(mk(OP_RD_SRC, 0, 0, 0, 0, 0, 0, ROP_SRCCOPY, '0),
                            'hffff_ffff, 0, 0, 0));
    steps.push_back(row_chk(mk(OP_RD_DST, 255, 255, 0, 0, 0, 0, ROP_SRCCOPY, '0),
                            'h1234_5678, 0, 0, 0));
    steps.push_back(row_chk(mk(OP_RD_SRC, 255, 255, 0, 0, 0, 0, ROP_SRCCOPY, '0),
                            'ha5a5_5a5a, 0, 0, 0));
    // clipped to a single pixel at the far corner
    steps.push_back(row_chk(mk(OP_BLIT, 255, 255, 255, 255, 256, 256, ROP_SRCCOPY, '0),
                            '0, 0, 1, 1));
    steps.push_back(row_chk(mk(OP_RD_DST, 255, 255, 0, 0, 0, 0, ROP_SRCCOPY, '0),
                            'ha5a5_5a5a, 0, 0, 0));
    steps.push_back(row_item(mk(OP_BLIT, 0, 0, 0, 0, 1, 1, ROP_SRCAND, '0)));
    steps.push_back(row_item(mk(OP_BLIT, 0, 0, 0, 0, 1, 1, ROP_SRCPAINT, '0)));
    steps.push_back(row_item(mk(OP_BLIT, 0, 0, 0, 0, 1, 1, ROP_SRCINVERT, '0)));
    steps.push_back(row_chk(mk(OP_RD_DST, 0, 0, 0, 0, 0, 0, ROP_SRCCOPY, '0), '0, 0, 0, 0));
    // unknown raster code leaves the destination alone
    steps.push_back(row_chk(mk(OP_BLIT, 0, 0, 255, 255, 256, 256, ROP_NOP, '0), '0, 0, 1, 1));
    steps.push_back(row_chk(mk(OP_RD_DST, 0, 0, 0, 0, 0, 0, ROP_SRCCOPY, '0), '0, 0, 0, 0));
    // empty rectangles and spare operation codes
    steps.push_back(row_chk(mk(OP_BLIT, 0, 0, 0, 0, 0, 5, ROP_SRCCOPY, '0), '0, 0, 0, 5));
    steps.push_back(row_chk(mk(OP_BLIT, 0, 0, 255, 0, 256, 0, ROP_SRCCOPY, '0), '0, 0, 1, 0));
    steps.push_back(row_chk(mk(OP_SPARE_HI, 255, 255, 255, 255, 256, 256, ROP_NOP,
                               'hffff_ffff), '0, 0, 0, 0));
    steps.push_back(row_chk(mk(OP_SPARE_LO, 1, 1, 1, 1, 1, 1, ROP_SRCCOPY, '0),
                            '0, 0, 0, 0));
    // empty source surface
    steps.push_back(row_cfg(REG_SRC_W, 0));
    steps.push_back(row_chk(mk(OP_RD_SRC, 0, 0, 0, 0, 0, 0, ROP_SRCCOPY, '0), '0, 1, 0, 0));
    steps.push_back(row_chk(mk(OP_BLIT, 0, 0, 0, 0, 1, 1, ROP_SRCCOPY, '0), '0, 1, 0, 0));
    // oversized width saturates, short destination
    steps.push_back(row_cfg(REG_SRC_W, 511));
    steps.push_back(row_cfg(REG_DST_H, 200));
    steps.push_back(row_chk(mk(OP_RD_SRC, 255, 255, 0, 0, 0, 0, ROP_SRCCOPY, '0),
                            'ha5a5_5a5a, 0, 0, 0));
    steps.push_back(row_chk(mk(OP_WR_DST, 0, 200, 0, 0, 0, 0, ROP_SRCCOPY, 'h5555_aaaa),
                            '0, 1, 0, 0));
    steps.push_back(row_chk(mk(OP_WR_DST, 0, 199, 0, 0, 0, 0, ROP_SRCCOPY, 'hdead_beef),
                            '0, 0, 0, 0));
    steps.push_back(row_chk(mk(OP_BLIT, 0, 199, 255, 255, 256, 256, ROP_SRCINVERT, '0),
                            '0, 0, 1, 1));
    steps.push_back(row_chk(mk(OP_BLIT, 0, 200, 0, 0, 1, 1, ROP_SRCCOPY, '0), '0, 1, 0, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < steps.size(); k++) begin
      if (steps[k].is_cfg) begin
        settle();
        write_reg(steps[k].cfg_reg, steps[k].cfg_val);
      end else begin
        want = compute_result(steps[k].c);
        if (steps[k].typed) want = steps[k].want;
        issue_beat(steps[k].c, want);
      end
    end

    run_setting(7, 5, 8, 6, 70);
    run_setting(511, 3, 1, 1, 70);
    settle();
    send_gap_pct = 84;
    recv_stall_pct = 12;
    run_setting(256, 256, 256, 256, 70);
    run_setting(0, 6, 6, 6, 70);
    settle();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    for (k = 0; k < 2; k++) run_setting(rand_dim(), rand_dim(), rand_dim(), rand_dim(), 70);

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[clipped_rop_blitter.f]
hw/rtl/crb_pkg.sv
hw/rtl/crb_regs.sv
hw/rtl/crb_ctrl.sv
hw/rtl/crb_dp.sv
hw/rtl/clipped_rop_blitter.sv
sim/tb_top.sv
